@@ sv/ezr_pkg.sv @@
// Package for the Euler ZYX rotation matrix block: constants, tables, helpers.
package ezr_pkg;

    localparam int ANGLE_W          = 16;
    localparam int OUT_W            = 18;
    localparam int Q_W              = 32;
    localparam int DEF_OUT_FRAC     = 16;
    localparam int DEF_ITERATIONS   = 16;
    localparam int MAX_ITERATIONS   = 31;

    localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT  = 16'sd23040;
    localparam logic signed [ANGLE_W-1:0] HALF_TURN    = 16'sd11520;
    localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 16'sd5760;

    localparam logic signed [Q_W-1:0] ONE_Q30  = 32'sd1073741824;
    localparam logic signed [Q_W-1:0] GAIN_Q30 = 32'sd652032874;
    localparam logic [34:0] DEG64_TO_RAD_Q46 = 35'd19190098067;

    typedef logic signed [Q_W-1:0] q30_t;

    function automatic q30_t atan_q30(input int i);
        q30_t r;
        r = '0;
        case (i)
            0: r = 32'sd843314857;
            1: r = 32'sd497837829;
            2: r = 32'sd263043837;
            3: r = 32'sd133525159;
            4: r = 32'sd67021687;
            5: r = 32'sd33543516;
            6: r = 32'sd16775851;
            7: r = 32'sd8388437;
            8: r = 32'sd4194283;
            9: r = 32'sd2097149;
            default: r = (i < MAX_ITERATIONS) ? q30_t'(32'sd1 <<< (30 - i)) : '0;
        endcase
        return r;
    endfunction

    function automatic q30_t sat_q30(input logic signed [Q_W+1:0] v);
        q30_t r;
        if (v > 34'(ONE_Q30))
            r = ONE_Q30;
        else if (v < -34'(ONE_Q30))
            r = -ONE_Q30;
        else
            r = q30_t'(v);
        return r;
    endfunction

    // floor((a*b + 2^29) / 2^30)
    function automatic q30_t mulq(input q30_t a, input q30_t b);
        logic signed [2*Q_W-1:0] p;
        p = 64'(a) * 64'(b) + 64'sd536870912;
        return q30_t'(p >>> 30);
    endfunction

endpackage

@@ sv/ezr_sincos.sv @@
// Pipelined CORDIC sine/cosine for one angle, one iteration per stage.
module ezr_sincos #(
    parameter int ITERATIONS = ezr_pkg::DEF_ITERATIONS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic signed [ezr_pkg::ANGLE_W-1:0] angle,
    output logic                               out_valid,
    output ezr_pkg::q30_t                      sin_q,
    output ezr_pkg::q30_t                      cos_q
);
    import ezr_pkg::*;

    localparam int N = (ITERATIONS > MAX_ITERATIONS) ? MAX_ITERATIONS : ITERATIONS;

    // stage 0: clamp/reduce; stage 1: radian convert; then N CORDIC stages
    logic                        v0_reg;
    logic signed [ANGLE_W-1:0]   a0_reg;
    logic                        nc0_reg;
    logic signed [ANGLE_W-1:0]   a0_next;
    logic                        nc0_next;

    always_comb
    begin
        logic signed [ANGLE_W:0] a;
        a = 17'(angle);
        nc0_next = 1'b0;
        if (a > 17'(ANGLE_LIMIT))
            a = 17'(ANGLE_LIMIT);
        if (a < -17'(ANGLE_LIMIT))
            a = -17'(ANGLE_LIMIT);
        if (a >= 17'(HALF_TURN))
            a = a - 17'(2 * HALF_TURN);
        if (a < -17'(HALF_TURN))
            a = a + 17'(2 * HALF_TURN);
        if (a > 17'(QUARTER_TURN))
        begin
            a = 17'(HALF_TURN) - a;
            nc0_next = 1'b1;
        end
        else if (a < -17'(QUARTER_TURN))
        begin
            a = -17'(HALF_TURN) - a;
            nc0_next = 1'b1;
        end
        a0_next = a[ANGLE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        a0_reg  <= a0_next;
        nc0_reg <= nc0_next;
    end

    logic  v1_reg;
    q30_t  z1_reg;
    logic  nc1_reg;
    logic  zero1_reg;
    logic  [ANGLE_W-1:0] mag0;
    logic  [50:0] prod0;
    q30_t  z1_next;

    assign mag0    = a0_reg[ANGLE_W-1] ? ANGLE_W'(-a0_reg) : ANGLE_W'(a0_reg);
    assign prod0   = 51'(mag0) * 51'(DEG64_TO_RAD_Q46);
    assign z1_next = a0_reg[ANGLE_W-1] ? -q30_t'(prod0 >> 16) : q30_t'(prod0 >> 16);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= v0_reg;
    end

    always_ff @(posedge clk)
    begin
        z1_reg    <= z1_next;
        nc1_reg   <= nc0_reg;
        zero1_reg <= (a0_reg == '0);
    end

    // wide x/y so saturation sees the overshoot
    logic                      v_reg    [N+1];
    logic signed [Q_W+1:0]     x_reg    [N+1];
    logic signed [Q_W+1:0]     y_reg    [N+1];
    q30_t                      z_reg    [N+1];
    logic                      nc_reg   [N+1];
    logic                      zero_reg [N+1];

    always_comb
    begin
        v_reg[0]    = v1_reg;
        x_reg[0]    = 34'(GAIN_Q30);
        y_reg[0]    = '0;
        z_reg[0]    = z1_reg;
        nc_reg[0]   = nc1_reg;
        zero_reg[0] = zero1_reg;
    end

    for (genvar i = 0; i < N; i++)
    begin : g_iter
        logic signed [Q_W+1:0] xs;
        logic signed [Q_W+1:0] ys;
        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else
                v_reg[i+1] <= v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (!z_reg[i][Q_W-1])
            begin
                x_reg[i+1] <= x_reg[i] - ys;
                y_reg[i+1] <= y_reg[i] + xs;
                z_reg[i+1] <= z_reg[i] - atan_q30(i);
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + ys;
                y_reg[i+1] <= y_reg[i] - xs;
                z_reg[i+1] <= z_reg[i] + atan_q30(i);
            end
            nc_reg[i+1]   <= nc_reg[i];
            zero_reg[i+1] <= zero_reg[i];
        end
    end

    logic  vo_reg;
    q30_t  s_reg;
    q30_t  c_reg;
    q30_t  xsat;

    assign xsat = sat_q30(x_reg[N]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else
            vo_reg <= v_reg[N];
    end

    always_ff @(posedge clk)
    begin
        if (zero_reg[N])
        begin
            s_reg <= '0;
            c_reg <= nc_reg[N] ? -ONE_Q30 : ONE_Q30;
        end
        else
        begin
            s_reg <= sat_q30(y_reg[N]);
            c_reg <= nc_reg[N] ? -xsat : xsat;
        end
    end

    assign out_valid = vo_reg;
    assign sin_q     = s_reg;
    assign cos_q     = c_reg;

endmodule

@@ sv/euler_zyx_rotation_matrix.sv @@
// Top level: Euler ZYX angles to 3x3 rotation matrix, fully pipelined.
//   channel  | ports                                   | handshake
//   command  | angle_x_deg, angle_y_deg, angle_z_deg   | start (busy is always low)
//   result   | m_r0c0 .. m_r2c2                        | done strobe, one cycle
// One word enters per cycle; the pipeline runs through reduction, radian
// conversion, the CORDIC stages, saturation, two product stages and output
// rounding.
// Reset clears only the valid bits. The receiver cannot stall, so nothing
// backs up and busy stays low.
module euler_zyx_rotation_matrix #(
    parameter int OUTPUT_FRAC_BITS  = ezr_pkg::DEF_OUT_FRAC,
    parameter int SINCOS_ITERATIONS = ezr_pkg::DEF_ITERATIONS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [ezr_pkg::ANGLE_W-1:0] angle_x_deg,
    input  logic signed [ezr_pkg::ANGLE_W-1:0] angle_y_deg,
    input  logic signed [ezr_pkg::ANGLE_W-1:0] angle_z_deg,
    output logic                               done,
    output logic signed [ezr_pkg::OUT_W-1:0]   m_r0c0,
    output logic signed [ezr_pkg::OUT_W-1:0]   m_r0c1,
    output logic signed [ezr_pkg::OUT_W-1:0]   m_r0c2,
    output logic signed [ezr_pkg::OUT_W-1:0]   m_r1c0,
    output logic signed [ezr_pkg::OUT_W-1:0]   m_r1c1,
    output logic signed [ezr_pkg::OUT_W-1:0]   m_r1c2,
    output logic signed [ezr_pkg::OUT_W-1:0]   m_r2c0,
    output logic signed [ezr_pkg::OUT_W-1:0]   m_r2c1,
    output logic signed [ezr_pkg::OUT_W-1:0]   m_r2c2
);
    import ezr_pkg::*;

    localparam int SH = (OUTPUT_FRAC_BITS < 30) ? 30 - OUTPUT_FRAC_BITS : 0;
    localparam logic signed [Q_W+1:0] LIM =
        (OUTPUT_FRAC_BITS < 30) ? (34'sd1 <<< OUTPUT_FRAC_BITS) : 34'(ONE_Q30);

    function automatic logic signed [OUT_W-1:0] to_out(input logic signed [Q_W+1:0] v);
        logic signed [Q_W+1:0] r;
        r = v;
        if (SH > 0)
            r = (v + (34'sd1 <<< (SH - 1))) >>> SH;
        if (r > LIM)
            r = LIM;
        if (r < -LIM)
            r = -LIM;
        return r[OUT_W-1:0];
    endfunction

    logic  vx, vy, vz;
    q30_t  sx, cx, sy, cy, sz, cz;

    assign busy = 1'b0;

    ezr_sincos #(.ITERATIONS(SINCOS_ITERATIONS)) u_x (
        .clk(clk), .rst_n(rst_n), .in_valid(start), .angle(angle_x_deg),
        .out_valid(vx), .sin_q(sx), .cos_q(cx));
    ezr_sincos #(.ITERATIONS(SINCOS_ITERATIONS)) u_y (
        .clk(clk), .rst_n(rst_n), .in_valid(start), .angle(angle_y_deg),
        .out_valid(vy), .sin_q(sy), .cos_q(cy));
    ezr_sincos #(.ITERATIONS(SINCOS_ITERATIONS)) u_z (
        .clk(clk), .rst_n(rst_n), .in_valid(start), .angle(angle_z_deg),
        .out_valid(vz), .sin_q(sz), .cos_q(cz));

    // stage A: first-level products
    logic  va_reg;
    q30_t  czsy_reg, szsy_reg, czcy_reg, szcy_reg, szcx_reg, szsx_reg;
    q30_t  czcx_reg, czsx_reg, cysx_reg, cycx_reg, nsy_reg, sxa_reg, cxa_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else
            va_reg <= vx & vy & vz;
    end

    always_ff @(posedge clk)
    begin
        czsy_reg <= mulq(cz, sy);
        szsy_reg <= mulq(sz, sy);
        czcy_reg <= mulq(cz, cy);
        szcy_reg <= mulq(sz, cy);
        szcx_reg <= mulq(sz, cx);
        szsx_reg <= mulq(sz, sx);
        czcx_reg <= mulq(cz, cx);
        czsx_reg <= mulq(cz, sx);
        cysx_reg <= mulq(cy, sx);
        cycx_reg <= mulq(cy, cx);
        nsy_reg  <= -sy;
        sxa_reg  <= sx;
        cxa_reg  <= cx;
    end

    // stage B: second-level products and sums
    logic                  vb_reg;
    logic signed [Q_W+1:0] e_reg [9];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vb_reg <= 1'b0;
        else
            vb_reg <= va_reg;
    end

    always_ff @(posedge clk)
    begin
        e_reg[0] <= 34'(czcy_reg);
        e_reg[1] <= 34'(mulq(czsy_reg, sxa_reg)) - 34'(szcx_reg);
        e_reg[2] <= 34'(mulq(czsy_reg, cxa_reg)) + 34'(szsx_reg);
        e_reg[3] <= 34'(szcy_reg);
        e_reg[4] <= 34'(mulq(szsy_reg, sxa_reg)) + 34'(czcx_reg);
        e_reg[5] <= 34'(mulq(szsy_reg, cxa_reg)) - 34'(czsx_reg);
        e_reg[6] <= 34'(nsy_reg);
        e_reg[7] <= 34'(cysx_reg);
        e_reg[8] <= 34'(cycx_reg);
    end

    // stage C: round and saturate
    logic                     vc_reg;
    logic signed [OUT_W-1:0]  o_reg [9];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vc_reg <= 1'b0;
        else
            vc_reg <= vb_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 9; k++)
            o_reg[k] <= to_out(e_reg[k]);
    end

    assign done   = vc_reg;
    assign m_r0c0 = o_reg[0];
    assign m_r0c1 = o_reg[1];
    assign m_r0c2 = o_reg[2];
    assign m_r1c0 = o_reg[3];
    assign m_r1c1 = o_reg[4];
    assign m_r1c2 = o_reg[5];
    assign m_r2c0 = o_reg[6];
    assign m_r2c1 = o_reg[7];
    assign m_r2c2 = o_reg[8];

endmodule
